>>> sv/rfcr_pkg.sv
// Package with the word types, reply descriptor and frame constants of the relay responder.
`default_nettype none
package rfcr_pkg;

	// Input word: one received byte and the switch levels sampled with it.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] ext_switches;
	} in_word_t;

	// Output word: one reply byte, its end marker and the relay levels.
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_last;
		logic [7:0] relay_drive;
	} out_word_t;

	// Reply descriptor passed from the front end to the transmitter.
	typedef struct packed {
		logic       is_nak;
		logic [7:0] sw_inv;
		logic [7:0] relay;
	} reply_t;

	// Frame bytes and command codes.
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] CMD_MARK   = 8'h05;
	localparam logic [7:0] FB_MARK    = 8'h06;
	localparam logic [7:0] NAK_MARK   = 8'h15;
	localparam logic [7:0] END_BYTE   = 8'h0D;
	localparam logic [7:0] CHECK_BYTE = 8'hAA;
	localparam logic [7:0] FB_BITS    = 8'hE0;
	localparam logic [7:0] CMD_QUERY  = 8'h3F;
	localparam logic [7:0] CMD_ON     = 8'hF0;
	localparam logic [7:0] CMD_OFF    = 8'h0F;

	// Byte positions within a ten-byte frame.
	localparam logic [3:0] POS_START = 4'd0;
	localparam logic [3:0] POS_MARK  = 4'd1;
	localparam logic [3:0] POS_ID    = 4'd2;
	localparam logic [3:0] POS_TYPE  = 4'd3;
	localparam logic [3:0] POS_SW_LO = 4'd4;
	localparam logic [3:0] POS_SW_HI = 4'd5;
	localparam logic [3:0] POS_RL_LO = 4'd6;
	localparam logic [3:0] POS_RL_HI = 4'd7;
	localparam logic [3:0] POS_CHECK = 4'd8;
	localparam logic [3:0] POS_END   = 4'd9;

	// Command frame positions of the command and mask bytes.
	localparam logic [3:0] POS_CMD  = 4'd4;
	localparam logic [3:0] POS_MASK = 4'd5;

	// Configuration register indexes.
	localparam logic CFG_MODULE_ID   = 1'b0;
	localparam logic CFG_MODULE_TYPE = 1'b1;

endpackage
`default_nettype wire

>>> sv/rfcr_front.sv
// Front end: gathers command frames, checks them, updates the relays and queues replies.
`default_nettype none
module rfcr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rfcr_pkg::in_word_t in_data,
	input  wire logic [7:0]        module_id,
	input  wire logic [7:0]        module_type,
	input  wire logic              q_full,
	output logic                   q_push,
	output rfcr_pkg::reply_t       q_entry
);

	logic       accept;
	logic [3:0] count_q;
	logic [3:0] count_d;
	logic [7:0] id_byte_q;
	logic [7:0] type_byte_q;
	logic [7:0] cmd_q;
	logic [7:0] mask_q;
	logic [7:0] check_q;
	logic [7:0] relay_q;
	logic [7:0] relay_d;
	logic       finish;
	logic       end_ok;
	logic       match;
	logic       reply;

	// A word is taken whenever the reply queue has room.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Frame position tracking; a bad start or mark byte empties the buffer.
	always_comb begin
		count_d = count_q;
		finish  = 1'b0;
		case (count_q)
			rfcr_pkg::POS_START: begin
				count_d = (in_data.rx_byte == rfcr_pkg::START_BYTE) ? 4'd1 : 4'd0;
			end
			rfcr_pkg::POS_MARK: begin
				count_d = (in_data.rx_byte == rfcr_pkg::CMD_MARK) ? 4'd2 : 4'd0;
			end
			rfcr_pkg::POS_END: begin
				count_d = 4'd0;
				finish  = 1'b1;
			end
			default: begin
				if (count_q inside {[rfcr_pkg::POS_ID : rfcr_pkg::POS_CHECK]}) begin
					count_d = count_q + 4'd1;
				end else begin
					count_d = 4'd0;
				end
			end
		endcase
	end

	// Frame checks on the tenth byte.
	assign end_ok = (in_data.rx_byte == rfcr_pkg::END_BYTE);
	assign match  = (check_q == rfcr_pkg::CHECK_BYTE) && (id_byte_q == module_id) &&
		(type_byte_q == module_type);

	// Command decode and relay update.
	always_comb begin
		relay_d = relay_q;
		reply   = 1'b0;
		if (!end_ok) begin
			reply = 1'b1;
		end else if (match) begin
			case (cmd_q)
				rfcr_pkg::CMD_QUERY: reply = 1'b1;
				rfcr_pkg::CMD_ON: begin
					relay_d = relay_q | mask_q;
					reply   = 1'b1;
				end
				rfcr_pkg::CMD_OFF: begin
					relay_d = relay_q & ~mask_q;
					reply   = 1'b1;
				end
				default: reply = 1'b0;
			endcase
		end
	end

	assign q_push         = accept && finish && reply;
	assign q_entry.is_nak = !end_ok;
	assign q_entry.sw_inv = ~in_data.ext_switches;
	assign q_entry.relay  = relay_d;

	// Control state: frame position and relay levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			relay_q <= 8'd0;
		end else if (accept) begin
			count_q <= count_d;
			if (finish) begin
				relay_q <= relay_d;
			end
		end
	end

	// Stored frame bytes that the decode reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q == rfcr_pkg::POS_ID)    id_byte_q   <= in_data.rx_byte;
			if (count_q == rfcr_pkg::POS_TYPE)  type_byte_q <= in_data.rx_byte;
			if (count_q == rfcr_pkg::POS_CMD)   cmd_q       <= in_data.rx_byte;
			if (count_q == rfcr_pkg::POS_MASK)  mask_q      <= in_data.rx_byte;
			if (count_q == rfcr_pkg::POS_CHECK) check_q     <= in_data.rx_byte;
		end
	end

endmodule
`default_nettype wire

>>> sv/rfcr_queue.sv
// Small first-in first-out queue of reply descriptors.
`default_nettype none
module rfcr_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rfcr_pkg::reply_t push_entry,
	input  wire logic             pop,
	output rfcr_pkg::reply_t      head,
	output logic                  empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rfcr_pkg::reply_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = (count_q == CNT_W'(0));
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/rfcr_back.sv
// Back end: sends each queued reply as a ten-byte frame, one word per cycle while out_ready is high.
`default_nettype none
module rfcr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       module_id,
	input  wire logic [7:0]       module_type,
	input  wire logic             q_empty,
	input  wire rfcr_pkg::reply_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rfcr_pkg::out_word_t   out_data
);

	logic             busy_q;
	logic [3:0]       pos_q;
	rfcr_pkg::reply_t cur_q;
	logic             last;
	logic             done;
	logic [7:0]       byte_d;

	assign last      = (pos_q == rfcr_pkg::POS_END);
	assign done      = out_ready && last;
	assign out_valid = busy_q;
	assign q_pop     = !q_empty && (!busy_q || done);

	// Reply byte for the current position.
	always_comb begin
		case (pos_q)
			rfcr_pkg::POS_START: byte_d = rfcr_pkg::START_BYTE;
			rfcr_pkg::POS_MARK:  byte_d = cur_q.is_nak ? rfcr_pkg::NAK_MARK : rfcr_pkg::FB_MARK;
			rfcr_pkg::POS_ID:    byte_d = module_id;
			rfcr_pkg::POS_TYPE:  byte_d = module_type;
			rfcr_pkg::POS_SW_LO: byte_d = rfcr_pkg::FB_BITS | {4'h0, cur_q.sw_inv[3:0]};
			rfcr_pkg::POS_SW_HI: byte_d = rfcr_pkg::FB_BITS | {4'h0, cur_q.sw_inv[7:4]};
			rfcr_pkg::POS_RL_LO: byte_d = rfcr_pkg::FB_BITS | {4'h0, cur_q.relay[3:0]};
			rfcr_pkg::POS_RL_HI: byte_d = rfcr_pkg::FB_BITS | {4'h0, cur_q.relay[7:4]};
			rfcr_pkg::POS_CHECK: byte_d = rfcr_pkg::CHECK_BYTE;
			rfcr_pkg::POS_END:   byte_d = rfcr_pkg::END_BYTE;
			default:             byte_d = 8'h00;
		endcase
	end

	assign out_data.tx_byte     = byte_d;
	assign out_data.frame_last  = last;
	assign out_data.relay_drive = cur_q.relay;

	// Frame sequencer: load a descriptor, step through its ten bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 4'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			pos_q  <= rfcr_pkg::POS_START;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
				pos_q  <= rfcr_pkg::POS_START;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// Descriptor of the reply being sent.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

endmodule
`default_nettype wire

>>> sv/relay_frame_command_responder_unit.sv
// Top level of the relay frame command responder: registers, front end, queue and transmitter.
// Input: one byte per cycle; ready drops only while the reply queue holds QDEPTH replies.
// The reply is pushed into the queue when the tenth command byte is taken, then popped into the transmitter.
// A reply waits in the queue while the transmitter is still sending an earlier one.
// Output: a reply is ten bytes, sent one byte per cycle by the transmitter while out_ready is high.
// Reset: arst_n clears the frame position, relays, queue and transmitter; ID and type reset to 1.
`default_nettype none
module relay_frame_command_responder_unit #(
	parameter int QDEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rfcr_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rfcr_pkg::out_word_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_wdata
);

	logic [7:0]       module_id_q;
	logic [7:0]       module_type_q;
	logic             q_push;
	logic             q_pop;
	logic             q_empty;
	logic             q_full;
	rfcr_pkg::reply_t q_in;
	rfcr_pkg::reply_t q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_id_q   <= 8'd1;
			module_type_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				rfcr_pkg::CFG_MODULE_ID:   module_id_q   <= cfg_wdata;
				rfcr_pkg::CFG_MODULE_TYPE: module_type_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rfcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.module_id  (module_id_q),
		.module_type(module_type_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_in)
	);

	rfcr_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	rfcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.module_id  (module_id_q),
		.module_type(module_type_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// A reply is never queued into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("reply pushed into a full queue");

	// With nothing queued, the output goes idle after the last byte of a reply.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.frame_last && q_empty) |=> !out_valid)
		else $error("output still valid after the final reply byte");

	// A reply frame that starts while the output was idle opens with the start byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> (out_data.tx_byte == rfcr_pkg::START_BYTE))
		else $error("reply frame does not open with the start byte");

	// A word is refused only while the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n) !in_ready |-> q_full)
		else $error("input stalled while the reply queue has room");

endmodule
`default_nettype wire

>>> test/relay_reply_checker.sv
// Checker that predicts and compares the reply words of the relay frame responder.
`timescale 1ns / 1ps
module relay_reply_checker
	import rfcr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_word_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_word_t out_data,
	input  wire logic      cfg_we,
	input  wire logic      cfg_index,
	input  wire logic [7:0] cfg_wdata,
	output int             words_due,
	output int             fault_count,
	output int             words_checked,
	output int             replies_checked
);

	localparam int FRAME_WORDS = 10;
	localparam int SHOWN_FAULTS = 10;

	// Shadow of the module registers, the command frame being gathered and the relays.
	logic [7:0] cfg_id;
	logic [7:0] cfg_type;
	logic [7:0] cmd_bytes [FRAME_WORDS];
	int         cmd_fill;
	logic [7:0] relay_state;

	// Reply words still owed by the block, oldest first.
	out_word_t  reply_words_due [$];
	int         faults;
	int         checked;
	int         replies;

	// Counts a mismatch and shows only the first few of them.
	function automatic void log_mismatch(input string what);
		faults++;
		if (faults <= SHOWN_FAULTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	// Queues the ten words of a feedback or NAK reply built from the current relays.
	function automatic void queue_reply(input logic [7:0] code, input logic [7:0] sw);
		logic [7:0] sw_inv;
		logic [7:0] body [FRAME_WORDS];
		sw_inv = ~sw;
		body[POS_START] = START_BYTE;
		body[POS_MARK]  = code;
		body[POS_ID]    = cfg_id;
		body[POS_TYPE]  = cfg_type;
		body[POS_SW_LO] = FB_BITS | {4'h0, sw_inv[3:0]};
		body[POS_SW_HI] = FB_BITS | {4'h0, sw_inv[7:4]};
		body[POS_RL_LO] = FB_BITS | {4'h0, relay_state[3:0]};
		body[POS_RL_HI] = FB_BITS | {4'h0, relay_state[7:4]};
		body[POS_CHECK] = CHECK_BYTE;
		body[POS_END]   = END_BYTE;
		for (int k = 0; k < FRAME_WORDS; k++)
			reply_words_due.push_back('{tx_byte: body[k], frame_last: (k == FRAME_WORDS - 1),
				relay_drive: relay_state});
	endfunction

	// Gathers one received byte into the command frame and acts on a complete frame.
	task automatic take_rx_byte(input logic [7:0] rx, input logic [7:0] sw);
		logic [7:0] mask;
		if (cmd_fill == 0) begin
			if (rx == START_BYTE) begin
				cmd_bytes[POS_START] = rx;
				cmd_fill = 1;
			end
		end else if (cmd_fill == 1) begin
			// A bad second byte drops the frame and is not taken as a new start.
			if (rx == CMD_MARK) begin
				cmd_bytes[POS_MARK] = rx;
				cmd_fill = 2;
			end else begin
				cmd_fill = 0;
			end
		end else begin
			cmd_bytes[cmd_fill] = rx;
			cmd_fill++;
			if (cmd_fill == FRAME_WORDS) begin
				mask = cmd_bytes[POS_MASK];
				if (cmd_bytes[POS_END] != END_BYTE) begin
					queue_reply(NAK_MARK, sw);
				end else if (cmd_bytes[POS_CHECK] == CHECK_BYTE && cmd_bytes[POS_ID] == cfg_id &&
					cmd_bytes[POS_TYPE] == cfg_type) begin
					case (cmd_bytes[POS_CMD])
						CMD_QUERY: begin
							queue_reply(FB_MARK, sw);
						end
						CMD_ON: begin
							relay_state = relay_state | mask;
							queue_reply(FB_MARK, sw);
						end
						CMD_OFF: begin
							relay_state = relay_state & ~mask;
							queue_reply(FB_MARK, sw);
						end
						default: ;
					endcase
				end
				cmd_fill = 0;
			end
		end
	endtask

	// Watch the three ports at each edge; the outputs to the top are registered.
	always @(posedge clk or negedge arst_n) begin
		out_word_t owed;
		if (!arst_n) begin
			cfg_id = 8'd1;
			cfg_type = 8'd1;
			cmd_fill = 0;
			relay_state = '0;
			reply_words_due.delete();
			faults = 0;
			checked = 0;
			replies = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MODULE_ID)
					cfg_id = cfg_wdata;
				else
					cfg_type = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (reply_words_due.size() == 0) begin
					log_mismatch($sformatf("word with nothing owed: tx %h last %b relay %h",
						out_data.tx_byte, out_data.frame_last, out_data.relay_drive));
				end else begin
					owed = reply_words_due.pop_front();
					if (owed.tx_byte !== out_data.tx_byte ||
						owed.frame_last !== out_data.frame_last ||
						owed.relay_drive !== out_data.relay_drive)
						log_mismatch($sformatf(
							"expected tx %h last %b relay %h, got tx %h last %b relay %h",
							owed.tx_byte, owed.frame_last, owed.relay_drive,
							out_data.tx_byte, out_data.frame_last, out_data.relay_drive));
					checked++;
					if (owed.frame_last)
						replies++;
				end
			end
			if (in_valid && in_ready)
				take_rx_byte(in_data.rx_byte, in_data.ext_switches);
		end
		words_due <= reply_words_due.size();
		fault_count <= faults;
		words_checked <= checked;
		replies_checked <= replies;
	end

endmodule

>>> test/tb_top.sv
// Testbench top that drives command bytes and module settings into the relay responder.
`timescale 1ns / 1ps
module tb_top;
	import rfcr_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int FRAME_WORDS = 10;
	localparam int PHASES = 4;
	localparam int PHASE_WORDS = 75;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	in_word_t   in_data = '0;
	logic       out_ready = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_MODULE_ID;
	logic [7:0] cfg_wdata = '0;
	logic       in_ready;
	logic       out_valid;
	out_word_t  out_data;

	int         words_due;
	int         fault_count;
	int         words_checked;
	int         replies_checked;

	// Stimulus bookkeeping shared with the receiver pacing.
	logic       idle_enable = 1'b1;
	int         words_sent = 0;
	int         settings_used = 1;
	logic [7:0] cur_id = 8'd1;
	logic [7:0] cur_type = 8'd1;

	always #1 clk = ~clk;

	relay_frame_command_responder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	relay_reply_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.words_due(words_due),
		.fault_count(fault_count),
		.words_checked(words_checked),
		.replies_checked(replies_checked)
	);

	// Offers one received word, after an optional gap, and returns at the edge that takes it.
	task automatic send_word(input logic [7:0] rx, input logic [7:0] sw);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{rx_byte: rx, ext_switches: sw};
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Sends a ten-byte command frame; the switch levels of the last byte shape the reply.
	task automatic send_command_frame(input logic [7:0] id, input logic [7:0] typ,
		input logic [7:0] cmd, input logic [7:0] mask, input logic [15:0] pad,
		input logic [7:0] chk, input logic [7:0] endb, input logic [7:0] last_sw);
		send_word(START_BYTE, 8'($urandom));
		send_word(CMD_MARK, 8'($urandom));
		send_word(id, 8'($urandom));
		send_word(typ, 8'($urandom));
		send_word(cmd, 8'($urandom));
		send_word(mask, 8'($urandom));
		send_word(pad[15:8], 8'($urandom));
		send_word(pad[7:0], 8'($urandom));
		send_word(chk, 8'($urandom));
		send_word(endb, last_sw);
	endtask

	// Lets every owed reply come out, then leaves the block time to go quiet.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both module registers on consecutive edges.
	task automatic program_module(input logic [7:0] id, input logic [7:0] typ);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODULE_ID;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_index <= CFG_MODULE_TYPE;
		cfg_wdata <= typ;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_id = id;
		cur_type = typ;
		settings_used++;
	endtask

	// Receiver pacing: random stall bursts, plus one long hold that backs the block up.
	initial begin : sink_pacing
		logic held_once;
		held_once = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!held_once && words_sent >= HOLD_AT) begin
				held_once = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run when no word has moved on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Directed frames first, then phases of mostly well-formed random traffic.
	initial begin : stimulus
		int         phase_words;
		int         pick;
		logic [7:0] fid;
		logic [7:0] ftype;
		logic [7:0] fcmd;
		logic [7:0] fchk;
		logic [7:0] fend;
		logic [7:0] rx;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad start byte, then a start followed by a second start that must not restart.
		send_word(8'h00, 8'hFF);
		send_word(START_BYTE, 8'h00);
		send_word(START_BYTE, 8'hFF);
		// ON with a full mask and all switches low, then a bad end byte, then OFF.
		send_command_frame(cur_id, cur_type, CMD_ON, 8'hFF, 16'h00FF, CHECK_BYTE, END_BYTE, 8'h00);
		send_command_frame(cur_id, cur_type, CMD_QUERY, 8'h00, 16'hFF00, CHECK_BYTE, 8'h00, 8'hFF);
		send_command_frame(cur_id, cur_type, CMD_OFF, 8'h5A, 16'($urandom), CHECK_BYTE, END_BYTE,
			8'($urandom));

		for (int ph = 1; ph <= PHASES; ph++) begin
			drain_and_settle();
			case (ph)
				1: program_module(8'h00, 8'hFF);
				2: program_module(8'hFF, 8'h00);
				default: program_module(8'($urandom), 8'($urandom));
			endcase
			// The last phase runs with both sides always willing.
			idle_enable = (ph != PHASES);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					if (pick < 6) begin
						// Line noise.
						repeat ($urandom_range(1, 4)) send_word(8'($urandom), 8'($urandom));
					end else begin
						send_word(START_BYTE, 8'($urandom));
						if (pick < 9) begin
							// Broken opening: a wrong second byte.
							rx = 8'($urandom);
							if (rx == CMD_MARK)
								rx = ~rx;
							send_word(rx, 8'($urandom));
						end else begin
							// Truncated frame that the next frame runs into.
							send_word(CMD_MARK, 8'($urandom));
							repeat ($urandom_range(1, 7)) send_word(8'($urandom), 8'($urandom));
						end
					end
				end else begin
					fid = cur_id;
					ftype = cur_type;
					fchk = CHECK_BYTE;
					fend = END_BYTE;
					case ($urandom_range(0, 2))
						0: fcmd = CMD_QUERY;
						1: fcmd = CMD_ON;
						default: fcmd = CMD_OFF;
					endcase
					if (pick < 20) begin
						fend = 8'($urandom);
						if (fend == END_BYTE)
							fend = ~fend;
					end else if (pick < 26) begin
						fchk = fchk ^ 8'($urandom_range(1, 255));
					end else if (pick < 30) begin
						fid = fid ^ 8'($urandom_range(1, 255));
					end else if (pick < 34) begin
						ftype = ftype ^ 8'($urandom_range(1, 255));
					end else if (pick < 40) begin
						fcmd = 8'($urandom);
						if (fcmd == CMD_QUERY || fcmd == CMD_ON || fcmd == CMD_OFF)
							fcmd = fcmd ^ 8'h01;
					end
					send_command_frame(fid, ftype, fcmd, 8'($urandom), 16'($urandom), fchk, fend,
						8'($urandom));
					phase_words += FRAME_WORDS;
				end
			end
		end

		drain_and_settle();
		$display("Summary: %0d bytes sent over %0d module settings, with a %0d-cycle output hold.",
			words_sent, settings_used, HOLD_CYCLES);
		$display("Summary: %0d reply words checked in %0d reply frames, %0d mismatches.",
			words_checked, replies_checked, fault_count);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
sv/rfcr_pkg.sv
sv/rfcr_front.sv
sv/rfcr_queue.sv
sv/rfcr_back.sv
sv/relay_frame_command_responder_unit.sv
test/relay_reply_checker.sv
test/tb_top.sv
